@@ hdl/bpmc_pkg.sv @@
// Shared types, codes and default constants of the battery power mode controller.
package bpmc_pkg;

    // Default timing and bit-position constants.
    localparam int DEF_NORMAL_TIMEOUT_S = 60;
    localparam int DEF_SETUP_TIMEOUT_S  = 120;
    localparam int DEF_SAFETY_POLL_S    = 5;
    localparam int DEF_BUS_RETRY_S      = 10;
    localparam int DEF_VBUS_FAULT_BIT   = 0;
    localparam logic [31:0] GEN_RETRY_S = 32'd5;

    // Mode codes.
    localparam logic [2:0] M_INIT  = 3'd0;
    localparam logic [2:0] M_CHG   = 3'd1;
    localparam logic [2:0] M_HOST  = 3'd2;
    localparam logic [2:0] M_IDLE  = 3'd3;
    localparam logic [2:0] M_FAULT = 3'd4;

    // Fault reason codes.
    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_BUS     = 3'd1;
    localparam logic [2:0] F_GAUGE   = 3'd2;
    localparam logic [2:0] F_CHARGER = 3'd3;
    localparam logic [2:0] F_INIT    = 3'd4;

    // Host event, device status and charge status codes.
    localparam logic [1:0] HEV_PACKET   = 2'd1;
    localparam logic [1:0] HEV_SHUTDOWN = 2'd2;
    localparam logic [1:0] DEV_OK       = 2'd0;
    localparam logic [1:0] DEV_BUS_FAIL = 2'd1;
    localparam logic [1:0] CS_OFF       = 2'd0;
    localparam logic [1:0] CS_CC        = 2'd1;
    localparam logic [1:0] CS_TAPER     = 2'd2;
    localparam logic [1:0] CS_TOPOFF    = 2'd3;

    // Register indexes.
    localparam logic [3:0] R_LOW_BATTERY   = 4'd0;
    localparam logic [3:0] R_CHARGE_START  = 4'd1;
    localparam logic [3:0] R_CHARGE_FULL   = 4'd2;
    localparam logic [3:0] R_WAKE_INTERVAL = 4'd3;
    localparam logic [3:0] R_GAUGE_CRIT    = 4'd4;
    localparam logic [3:0] R_GAUGE_RECOVER = 4'd5;
    localparam logic [3:0] R_CHG_CRIT      = 4'd6;
    localparam logic [3:0] R_CHG_RECOVER   = 4'd7;

    // One poll, last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  chg_flags;
        logic [31:0] safety_status;
        logic        gauge_discharging;
        logic [1:0]  charge_status;
        logic        ac_online;
        logic [15:0] vbat_mv;
        logic [1:0]  device_status;
        logic [1:0]  host_event;
        logic        hall_wake;
        logic [1:0]  tick;
    } poll_t;

    // One result, last field in the lowest bits.
    typedef struct packed {
        logic       low_battery;
        logic [2:0] fault_reason;
        logic       setup_wake_line;
        logic       charger_enabled;
        logic       host_power_on;
        logic [2:0] mode_state;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [12:0] low_battery_mv;
        logic [12:0] charge_start_mv;
        logic [12:0] charge_full_mv;
        logic [15:0] wake_interval_min;
        logic [31:0] gauge_critical_mask;
        logic [31:0] gauge_recover_mask;
        logic [7:0]  charger_critical_mask;
        logic [7:0]  charger_recover_mask;
    } cfg_t;

endpackage

@@ hdl/bpmc_cfg.sv @@
// Configuration register file of the battery power mode controller.
module bpmc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output bpmc_pkg::cfg_t      cfg
);
    import bpmc_pkg::*;

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_battery_mv        <= 13'd3000;
            cfg_reg.charge_start_mv       <= 13'd3400;
            cfg_reg.charge_full_mv        <= 13'd3650;
            cfg_reg.wake_interval_min     <= 16'd15;
            cfg_reg.gauge_critical_mask   <= '0;
            cfg_reg.gauge_recover_mask    <= '0;
            cfg_reg.charger_critical_mask <= '0;
            cfg_reg.charger_recover_mask  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                R_LOW_BATTERY:   cfg_reg.low_battery_mv        <= cfg_data[12:0];
                R_CHARGE_START:  cfg_reg.charge_start_mv       <= cfg_data[12:0];
                R_CHARGE_FULL:   cfg_reg.charge_full_mv        <= cfg_data[12:0];
                R_WAKE_INTERVAL: cfg_reg.wake_interval_min     <= cfg_data[15:0];
                R_GAUGE_CRIT:    cfg_reg.gauge_critical_mask   <= cfg_data;
                R_GAUGE_RECOVER: cfg_reg.gauge_recover_mask    <= cfg_data;
                R_CHG_CRIT:      cfg_reg.charger_critical_mask <= cfg_data[7:0];
                R_CHG_RECOVER:   cfg_reg.charger_recover_mask  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/bpmc_core.sv @@
// Mode state, timers and one-poll update logic of the battery power mode controller.
module bpmc_core #(
    parameter int NORMAL_TIMEOUT_S = bpmc_pkg::DEF_NORMAL_TIMEOUT_S,
    parameter int SETUP_TIMEOUT_S  = bpmc_pkg::DEF_SETUP_TIMEOUT_S,
    parameter int SAFETY_POLL_S    = bpmc_pkg::DEF_SAFETY_POLL_S,
    parameter int BUS_RETRY_S      = bpmc_pkg::DEF_BUS_RETRY_S,
    parameter int VBUS_FAULT_BIT   = bpmc_pkg::DEF_VBUS_FAULT_BIT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bpmc_pkg::poll_t     poll,
    input  bpmc_pkg::cfg_t      cfg,
    output bpmc_pkg::result_t   result
);
    import bpmc_pkg::*;

    localparam logic [31:0] NORMAL_T = 32'(NORMAL_TIMEOUT_S);
    localparam logic [31:0] SETUP_T  = 32'(SETUP_TIMEOUT_S);
    localparam logic [31:0] SAFETY_T = 32'(SAFETY_POLL_S);
    localparam logic [31:0] BUS_T    = 32'(BUS_RETRY_S);
    localparam logic [2:0]  VBUS_IDX = 3'(VBUS_FAULT_BIT);

    logic [2:0]  mode_reg, mode_next;
    logic        entry_reg, entry_next;
    logic [31:0] sec_reg, sec_next, min_reg, min_next;
    logic [31:0] lsp_reg, lsp_next, lcm_reg, lcm_next;
    logic [31:0] ism_reg, ism_next, lpm_reg, lpm_next;
    logic [31:0] hos_reg, hos_next, has_reg, has_next, rms_reg, rms_next;
    logic        sw_reg, sw_next, lms_reg, lms_next;
    logic        chg_reg, chg_next, hon_reg, hon_next;
    logic [2:0]  fk_reg, fk_next;

    // Per-poll classification of the live inputs.
    logic crit_low, is_chg, g_any, g_crit, g_rec, c_any, c_crit, c_dis, below_start;
    assign crit_low    = (poll.vbat_mv < {3'b000, cfg.low_battery_mv}) && !poll.ac_online;
    assign below_start = poll.vbat_mv < {3'b000, cfg.charge_start_mv};
    assign is_chg      = !poll.gauge_discharging || poll.charge_status == CS_CC
                         || poll.charge_status == CS_TAPER;
    assign g_any  = poll.safety_status != '0;
    assign g_crit = (poll.safety_status & cfg.gauge_critical_mask) != '0;
    assign g_rec  = (poll.safety_status & cfg.gauge_recover_mask) != '0;
    assign c_any  = poll.chg_flags != '0;
    assign c_crit = (poll.chg_flags & cfg.charger_critical_mask) != '0;
    assign c_dis  = ((poll.chg_flags & cfg.charger_recover_mask) != '0)
                    || (poll.chg_flags[VBUS_IDX] && poll.ac_online);

    // Next state for one poll, written in the order the actions happen.
    always_comb
    begin
        logic hall_l;
        logic done;
        logic pdue;
        mode_next  = mode_reg;  entry_next = entry_reg;
        sec_next   = sec_reg;   min_next   = min_reg;
        lsp_next   = lsp_reg;   lcm_next   = lcm_reg;
        ism_next   = ism_reg;   lpm_next   = lpm_reg;
        hos_next   = hos_reg;   has_next   = has_reg;
        rms_next   = rms_reg;   sw_next    = sw_reg;
        lms_next   = lms_reg;   chg_next   = chg_reg;
        hon_next   = hon_reg;   fk_next    = fk_reg;
        hall_l     = poll.hall_wake;
        done       = 1'b0;
        pdue       = 1'b0;

        // Tick counters and the periodic gauge safety check.
        if (poll.tick[1])
            min_next = min_reg + 32'd1;
        if (poll.tick[0])
        begin
            sec_next = sec_reg + 32'd1;
            if (sec_next - lsp_reg >= SAFETY_T)
            begin
                lsp_next = sec_next;
                if (mode_reg != M_FAULT && mode_reg != M_INIT && g_any)
                begin
                    if (g_crit)
                    begin
                        fk_next    = F_GAUGE;
                        mode_next  = M_FAULT;
                        entry_next = 1'b0;
                    end
                    else if (g_rec)
                        chg_next = 1'b0;
                end
            end
        end

        case (mode_next)
            M_INIT:
            begin
                if (!entry_next)
                begin
                    entry_next = 1'b0;
                    if (poll.device_status == DEV_BUS_FAIL)
                    begin
                        fk_next   = F_BUS;
                        mode_next = M_FAULT;
                    end
                    else if (poll.device_status != DEV_OK)
                    begin
                        fk_next   = F_INIT;
                        mode_next = M_FAULT;
                    end
                    else if (crit_low)
                        mode_next = M_IDLE;
                    else if (below_start && poll.ac_online)
                        mode_next = M_CHG;
                    else
                        mode_next = M_HOST;
                end
            end
            M_CHG:
            begin
                if (!entry_next)
                begin
                    chg_next   = 1'b1;
                    lms_next   = 1'b0;
                    entry_next = 1'b1;
                    lcm_next   = min_next + 32'd1;
                end
                if (poll.hall_wake)
                begin
                    sw_next    = 1'b1;
                    mode_next  = M_HOST;
                    entry_next = 1'b0;
                end
                else if (min_next != lcm_next)
                begin
                    lcm_next = min_next;
                    if (g_any && !g_crit && g_rec)
                        chg_next = 1'b0;
                    if (g_any && g_crit)
                    begin
                        fk_next    = F_GAUGE;
                        mode_next  = M_FAULT;
                        entry_next = 1'b0;
                    end
                    else
                    begin
                        if (c_any && !c_crit && c_dis)
                            chg_next = 1'b0;
                        pdue = !(crit_low && lms_next) && (min_next - lpm_next
                               >= {16'h0000, cfg.wake_interval_min});
                        if (c_any && c_crit)
                        begin
                            fk_next    = F_CHARGER;
                            mode_next  = M_FAULT;
                            entry_next = 1'b0;
                        end
                        else if (poll.vbat_mv >= {3'b000, cfg.charge_full_mv}
                                 || poll.charge_status == CS_OFF
                                 || poll.charge_status == CS_TOPOFF)
                        begin
                            chg_next   = 1'b0;
                            mode_next  = M_IDLE;
                            entry_next = 1'b0;
                        end
                        else if (pdue)
                        begin
                            lpm_next   = min_next;
                            mode_next  = M_HOST;
                            entry_next = 1'b0;
                        end
                    end
                end
            end
            M_HOST:
            begin
                if (!entry_next)
                begin
                    hon_next   = 1'b1;
                    hos_next   = sec_next;
                    has_next   = sec_next;
                    entry_next = 1'b1;
                    if (crit_low)
                        lms_next = 1'b1;
                end
                if (poll.host_event == HEV_PACKET)
                    has_next = sec_next;
                if (poll.host_event == HEV_SHUTDOWN
                    || (!sw_next && (sec_next - hos_next >= NORMAL_T))
                    || (sw_next && (sec_next - has_next >= SETUP_T)))
                begin
                    // Host off, then resume charging (entry skipped) or go idle.
                    hon_next   = 1'b0;
                    mode_next  = is_chg ? M_CHG : M_IDLE;
                    entry_next = is_chg;
                end
            end
            M_IDLE:
            begin
                if (!entry_next)
                begin
                    sw_next    = 1'b0;
                    hon_next   = 1'b0;
                    ism_next   = min_next;
                    chg_next   = below_start;
                    entry_next = 1'b1;
                    hall_l     = 1'b0;
                end
                if (ism_next != min_next)
                begin
                    ism_next = min_next;
                    if (g_any && !g_crit && g_rec)
                        chg_next = 1'b0;
                    pdue = !(crit_low && lms_next) && (min_next - lpm_next
                           >= {16'h0000, cfg.wake_interval_min});
                    if (g_any && g_crit)
                    begin
                        fk_next    = F_GAUGE;
                        mode_next  = M_FAULT;
                        entry_next = 1'b0;
                        done       = 1'b1;
                    end
                    else if (is_chg)
                    begin
                        mode_next  = M_CHG;
                        entry_next = 1'b0;
                        done       = 1'b1;
                    end
                    else if (pdue)
                    begin
                        lpm_next   = min_next;
                        mode_next  = M_HOST;
                        entry_next = 1'b0;
                        done       = 1'b1;
                    end
                end
                if (!done && hall_l)
                begin
                    sw_next    = 1'b1;
                    mode_next  = M_HOST;
                    entry_next = 1'b0;
                end
            end
            M_FAULT:
            begin
                if (!entry_next)
                begin
                    hon_next   = 1'b0;
                    chg_next   = 1'b0;
                    rms_next   = sec_next;
                    entry_next = 1'b1;
                end
                // Init failure holds until reset; others retry on a timer.
                if (fk_next != F_INIT
                    && (sec_next - rms_next >= ((fk_next == F_BUS) ? BUS_T : GEN_RETRY_S)))
                begin
                    rms_next = sec_next;
                    if (fk_next == F_BUS)
                    begin
                        if (poll.device_status != DEV_BUS_FAIL)
                        begin
                            mode_next  = M_INIT;
                            entry_next = 1'b0;
                        end
                    end
                    else if (!g_any && !c_any)
                    begin
                        mode_next  = M_IDLE;
                        entry_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers advance once per accepted poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_INIT;  entry_reg <= 1'b0;
            sec_reg   <= '0;      min_reg   <= '0;
            lsp_reg   <= '0;      lcm_reg   <= '0;
            ism_reg   <= '0;      lpm_reg   <= '0;
            hos_reg   <= '0;      has_reg   <= '0;
            rms_reg   <= '0;      sw_reg    <= 1'b0;
            lms_reg   <= 1'b0;    chg_reg   <= 1'b0;
            hon_reg   <= 1'b0;    fk_reg    <= F_NONE;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;  entry_reg <= entry_next;
            sec_reg   <= sec_next;   min_reg   <= min_next;
            lsp_reg   <= lsp_next;   lcm_reg   <= lcm_next;
            ism_reg   <= ism_next;   lpm_reg   <= lpm_next;
            hos_reg   <= hos_next;   has_reg   <= has_next;
            rms_reg   <= rms_next;   sw_reg    <= sw_next;
            lms_reg   <= lms_next;   chg_reg   <= chg_next;
            hon_reg   <= hon_next;   fk_reg    <= fk_next;
        end
    end

    // Result of this poll, taken from the post-poll state.
    assign result.mode_state      = mode_next;
    assign result.host_power_on   = hon_next;
    assign result.charger_enabled = chg_next;
    assign result.setup_wake_line = hon_next && sw_next;
    assign result.fault_reason    = fk_next;
    assign result.low_battery     = crit_low;

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= M_FAULT) else $error("mode code out of range");
    a_fault_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_FAULT |-> fk_reg != F_NONE) else $error("fault mode without reason");
    a_host_power_mode: assert property (@(posedge clk) disable iff (!rst_n)
        hon_reg |-> mode_reg == M_HOST) else $error("host powered outside host mode");

endmodule

@@ hdl/battery_power_mode_controller.sv @@
// Top level of the battery power mode controller: stream ports, input and result registers.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         72     one poll (fields listed at the port)
//  m_axis    out        16     one result (fields listed at the port)
//  cfg       in         32     register write, index 0 to 7
//
// A poll is registered on transfer, evaluated combinationally by the mode logic and its
// result registered, so one poll per cycle is sustained while m_axis takes each result.
// The input register and the result register are separate stages: a new poll is taken
// while a result waits, and a stall on m_axis reaches s_axis only when both are full.
// Reset clears the mode, all second and minute counters and the registers to defaults.
module battery_power_mode_controller #(
    parameter int NORMAL_TIMEOUT_S = bpmc_pkg::DEF_NORMAL_TIMEOUT_S,
    parameter int SETUP_TIMEOUT_S  = bpmc_pkg::DEF_SETUP_TIMEOUT_S,
    parameter int SAFETY_POLL_S    = bpmc_pkg::DEF_SAFETY_POLL_S,
    parameter int BUS_RETRY_S      = bpmc_pkg::DEF_BUS_RETRY_S,
    parameter int VBUS_FAULT_BIT   = bpmc_pkg::DEF_VBUS_FAULT_BIT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tick[1:0], hall_wake[2], host_event[4:3], device_status[6:5], vbat_mv[22:7],
    // ac_online[23], charge_status[25:24], gauge_discharging[26],
    // safety_status[58:27], chg_flags[66:59], zero fill above
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode_state[2:0], host_power_on[3], charger_enabled[4], setup_wake_line[5],
    // fault_reason[8:6], low_battery[9], zero fill above
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bpmc_pkg::*;

    logic    in_valid_reg;
    poll_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    bpmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpmc_core #(
        .NORMAL_TIMEOUT_S (NORMAL_TIMEOUT_S),
        .SETUP_TIMEOUT_S  (SETUP_TIMEOUT_S),
        .SAFETY_POLL_S    (SAFETY_POLL_S),
        .BUS_RETRY_S      (BUS_RETRY_S),
        .VBUS_FAULT_BIT   (VBUS_FAULT_BIT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .poll   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= s_axis_tdata[$bits(poll_t)-1:0];
    end

    // Result stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_item_reg};

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg) else $error("result lost after evaluation");
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending poll dropped");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready) else $error("empty input stage not ready");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the battery power mode controller.
`timescale 1ns / 100ps

module tb_top;
    import bpmc_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_POLLS = 480;
    localparam logic [3:0]  R_UNMAPPED  = 4'd11;
    localparam logic [31:0] SAFETY_S    = 32'(DEF_SAFETY_POLL_S);
    localparam logic [31:0] NORMAL_S    = 32'(DEF_NORMAL_TIMEOUT_S);
    localparam logic [31:0] SETUP_S     = 32'(DEF_SETUP_TIMEOUT_S);
    localparam logic [31:0] BUS_RETRY   = 32'(DEF_BUS_RETRY_S);

    typedef struct {
        int      seq;
        result_t res;
    } fixed_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Shared run state between stimulus, receiver and monitor.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int pressure_phase = 1;
    int polls_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    result_t       expected_results[$];
    fixed_result_t fixed_results[$];

    // Mirror of the controller's registers and state.
    cfg_t        cfg_mirror;
    poll_t       cur;
    logic [2:0]  mode, fault;
    logic        entry_seen, setup, low_sent, chg_on, host_pwr;
    logic [31:0] sec_cnt, min_cnt, safety_mark, charge_min, idle_min, periodic_min;
    logic [31:0] host_on_at, host_act_at, retry_at;

    battery_power_mode_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter with a hard stop.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void clear_model();
        cfg_mirror.low_battery_mv        = 13'd3000;
        cfg_mirror.charge_start_mv       = 13'd3400;
        cfg_mirror.charge_full_mv        = 13'd3650;
        cfg_mirror.wake_interval_min     = 16'd15;
        cfg_mirror.gauge_critical_mask   = '0;
        cfg_mirror.gauge_recover_mask    = '0;
        cfg_mirror.charger_critical_mask = '0;
        cfg_mirror.charger_recover_mask  = '0;
        mode = M_INIT;
        fault = F_NONE;
        {entry_seen, setup, low_sent, chg_on, host_pwr} = '0;
        {sec_cnt, min_cnt, safety_mark, charge_min, idle_min} = '0;
        {periodic_min, host_on_at, host_act_at, retry_at} = '0;
    endfunction

    function automatic void go(input logic [2:0] m);
        mode = m;
        entry_seen = 1'b0;
    endfunction

    function automatic bit battery_low();
        return (cur.vbat_mv < {3'b0, cfg_mirror.low_battery_mv}) && !cur.ac_online;
    endfunction

    function automatic bit charging_seen();
        return !cur.gauge_discharging || cur.charge_status == CS_CC ||
               cur.charge_status == CS_TAPER;
    endfunction

    // Gauge word classification; true when it forced the fault mode.
    function automatic bit gauge_fault();
        bit crit;
        if (mode == M_FAULT || mode == M_INIT || cur.safety_status == '0)
            return 1'b0;
        crit = (cur.safety_status & cfg_mirror.gauge_critical_mask) != '0;
        if (!crit && (cur.safety_status & cfg_mirror.gauge_recover_mask) != '0)
            chg_on = 1'b0;
        if (crit)
        begin
            fault = F_GAUGE;
            go(M_FAULT);
        end
        return crit;
    endfunction

    function automatic bit chg_flags_hit();
        bit crit, dis;
        if (cur.chg_flags == '0)
            return 1'b0;
        crit = (cur.chg_flags & cfg_mirror.charger_critical_mask) != '0;
        dis = (cur.chg_flags & cfg_mirror.charger_recover_mask) != '0;
        if (cur.chg_flags[DEF_VBUS_FAULT_BIT] && cur.ac_online)
            dis = 1'b1;
        if (!crit && dis)
            chg_on = 1'b0;
        if (crit)
        begin
            fault = F_CHARGER;
            go(M_FAULT);
        end
        return crit;
    endfunction

    function automatic bit wake_due();
        logic [31:0] gap;
        gap = min_cnt - periodic_min;
        if (battery_low() && low_sent)
            return 1'b0;
        return gap >= {16'b0, cfg_mirror.wake_interval_min};
    endfunction

    function automatic void host_off();
        host_pwr = 1'b0;
        if (charging_seen())
        begin
            go(M_CHG);
            entry_seen = 1'b1;
        end
        else
            go(M_IDLE);
    endfunction

    // Mode logic for one poll.
    function automatic void step_mode(input logic hall_in, input logic [1:0] hev);
        logic [31:0] span, interval;
        bit left;
        logic hall;
        left = 1'b0;
        hall = hall_in;
        case (mode)
            M_INIT:
            begin
                if (!entry_seen)
                begin
                    if (cur.device_status == DEV_BUS_FAIL)
                    begin
                        fault = F_BUS;
                        go(M_FAULT);
                    end
                    else if (cur.device_status != DEV_OK)
                    begin
                        fault = F_INIT;
                        go(M_FAULT);
                    end
                    else if (battery_low())
                        go(M_IDLE);
                    else if (cur.vbat_mv < {3'b0, cfg_mirror.charge_start_mv} &&
                             cur.ac_online)
                        go(M_CHG);
                    else
                        go(M_HOST);
                end
            end
            M_CHG:
            begin
                if (!entry_seen)
                begin
                    chg_on = 1'b1;
                    low_sent = 1'b0;
                    entry_seen = 1'b1;
                    charge_min = min_cnt + 1;
                end
                if (hall)
                begin
                    setup = 1'b1;
                    go(M_HOST);
                end
                else if (min_cnt != charge_min)
                begin
                    charge_min = min_cnt;
                    if (!(gauge_fault() || chg_flags_hit()))
                    begin
                        if (cur.vbat_mv >= {3'b0, cfg_mirror.charge_full_mv} ||
                            cur.charge_status == CS_OFF || cur.charge_status == CS_TOPOFF)
                        begin
                            chg_on = 1'b0;
                            go(M_IDLE);
                        end
                        else if (wake_due())
                        begin
                            periodic_min = min_cnt;
                            go(M_HOST);
                        end
                    end
                end
            end
            M_HOST:
            begin
                if (!entry_seen)
                begin
                    host_pwr = 1'b1;
                    host_on_at = sec_cnt;
                    host_act_at = sec_cnt;
                    entry_seen = 1'b1;
                    if (battery_low())
                        low_sent = 1'b1;
                end
                if (hev == HEV_SHUTDOWN)
                    host_off();
                else
                begin
                    if (hev == HEV_PACKET)
                        host_act_at = sec_cnt;
                    if (!setup)
                    begin
                        span = sec_cnt - host_on_at;
                        if (span >= NORMAL_S)
                            host_off();
                    end
                    else
                    begin
                        span = sec_cnt - host_act_at;
                        if (span >= SETUP_S)
                            host_off();
                    end
                end
            end
            M_IDLE:
            begin
                if (!entry_seen)
                begin
                    setup = 1'b0;
                    host_pwr = 1'b0;
                    idle_min = min_cnt;
                    chg_on = cur.vbat_mv < {3'b0, cfg_mirror.charge_start_mv};
                    entry_seen = 1'b1;
                    hall = 1'b0;
                end
                if (idle_min != min_cnt)
                begin
                    idle_min = min_cnt;
                    if (gauge_fault())
                        left = 1'b1;
                    else if (charging_seen())
                    begin
                        go(M_CHG);
                        left = 1'b1;
                    end
                    else if (wake_due())
                    begin
                        periodic_min = min_cnt;
                        go(M_HOST);
                        left = 1'b1;
                    end
                end
                if (!left && hall)
                begin
                    setup = 1'b1;
                    go(M_HOST);
                end
            end
            M_FAULT:
            begin
                if (!entry_seen)
                begin
                    host_pwr = 1'b0;
                    chg_on = 1'b0;
                    retry_at = sec_cnt;
                    entry_seen = 1'b1;
                end
                if (fault != F_INIT)
                begin
                    interval = (fault == F_BUS) ? BUS_RETRY : GEN_RETRY_S;
                    span = sec_cnt - retry_at;
                    if (span >= interval)
                    begin
                        retry_at = sec_cnt;
                        if (fault == F_BUS)
                        begin
                            if (cur.device_status != DEV_BUS_FAIL)
                                go(M_INIT);
                        end
                        else if (cur.safety_status == '0 && cur.chg_flags == '0)
                            go(M_IDLE);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Expected result of one accepted poll.
    function automatic result_t predict_poll(input poll_t p);
        result_t r;
        logic [31:0] span;
        cur = p;
        if (p.tick[1])
            min_cnt = min_cnt + 1;
        if (p.tick[0])
        begin
            sec_cnt = sec_cnt + 1;
            span = sec_cnt - safety_mark;
            if (span >= SAFETY_S)
            begin
                safety_mark = sec_cnt;
                void'(gauge_fault());
            end
        end
        step_mode(p.hall_wake, p.host_event);
        r.mode_state = mode;
        r.host_power_on = host_pwr;
        r.charger_enabled = chg_on;
        r.setup_wake_line = host_pwr && setup;
        r.fault_reason = fault;
        r.low_battery = battery_low();
        return r;
    endfunction

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge clk)
    begin
        result_t exp_r, got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_r = predict_poll(poll_t'(s_axis_tdata[66:0]));
                if (fixed_results.size() > 0 && fixed_results[0].seq == polls_taken)
                    exp_r = fixed_results.pop_front().res;
                expected_results.push_back(exp_r);
                polls_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[9:0]);
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer %h", got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.mode_state !== exp_r.mode_state ||
                        got.host_power_on !== exp_r.host_power_on ||
                        got.charger_enabled !== exp_r.charger_enabled ||
                        got.setup_wake_line !== exp_r.setup_wake_line ||
                        got.fault_reason !== exp_r.fault_reason ||
                        got.low_battery !== exp_r.low_battery)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d mismatch: expected %p, got %p",
                                     results_seen, exp_r, got);
                    end
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the pipeline.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && pressure_phase == 0 && results_seen >= 40)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic poll_t make_poll(input logic [1:0] tick, input logic hall,
                                        input logic [1:0] hev, input logic [1:0] dev,
                                        input logic [15:0] vbat, input logic adapter,
                                        input logic [1:0] cs, input logic dsg,
                                        input logic [31:0] gs, input logic [7:0] cf);
        poll_t p;
        p.tick = tick;
        p.hall_wake = hall;
        p.host_event = hev;
        p.device_status = dev;
        p.vbat_mv = vbat;
        p.ac_online = adapter;
        p.charge_status = cs;
        p.gauge_discharging = dsg;
        p.safety_status = gs;
        p.chg_flags = cf;
        return p;
    endfunction

    // Random poll, mostly plausible: voltages near a threshold, rare fault words.
    function automatic poll_t random_poll(input bit allow_init_fail);
        poll_t p;
        int roll;
        logic [15:0] center;
        p.tick = 2'($urandom_range(3));
        p.hall_wake = ($urandom_range(11) == 0);
        roll = $urandom_range(99);
        p.host_event = (roll < 79) ? 2'd0 : (roll < 94) ? HEV_PACKET :
                       (roll < 98) ? HEV_SHUTDOWN : 2'd3;
        roll = $urandom_range(99);
        if (allow_init_fail)
            p.device_status = 2'($urandom_range(3));
        else
            p.device_status = (roll < 6) ? DEV_BUS_FAIL : DEV_OK;
        roll = $urandom_range(99);
        case ($urandom_range(2))
            0: center = {3'b0, cfg_mirror.low_battery_mv};
            1: center = {3'b0, cfg_mirror.charge_start_mv};
            default: center = {3'b0, cfg_mirror.charge_full_mv};
        endcase
        if (roll < 80)
            p.vbat_mv = center + 16'($urandom_range(200)) - 16'd100;
        else if (roll < 90)
            p.vbat_mv = 16'($urandom);
        else if (roll < 95)
            p.vbat_mv = '0;
        else
            p.vbat_mv = '1;
        p.ac_online = 1'($urandom_range(1));
        p.charge_status = 2'($urandom_range(3));
        p.gauge_discharging = 1'($urandom_range(1));
        roll = $urandom_range(99);
        p.safety_status = (roll < 88) ? '0 : (roll < 94) ? (32'd1 << $urandom_range(31)) :
                          $urandom;
        roll = $urandom_range(99);
        p.chg_flags = (roll < 88) ? '0 : (roll < 94) ? (8'd1 << $urandom_range(7)) :
                      8'($urandom);
        return p;
    endfunction

    // Offer one poll and hold it until the transfer happens.
    task automatic send_poll(input poll_t p);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, p};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Wait for all results to drain, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Register writes on back-to-back cycles, mirrored in the predictor.
    task automatic write_regs(input logic [31:0] vals[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 4'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_mirror.low_battery_mv        = vals[R_LOW_BATTERY][12:0];
        cfg_mirror.charge_start_mv       = vals[R_CHARGE_START][12:0];
        cfg_mirror.charge_full_mv        = vals[R_CHARGE_FULL][12:0];
        cfg_mirror.wake_interval_min     = vals[R_WAKE_INTERVAL][15:0];
        cfg_mirror.gauge_critical_mask   = vals[R_GAUGE_CRIT];
        cfg_mirror.gauge_recover_mask    = vals[R_GAUGE_RECOVER];
        cfg_mirror.charger_critical_mask = vals[R_CHG_CRIT][7:0];
        cfg_mirror.charger_recover_mask  = vals[R_CHG_RECOVER][7:0];
        // A write to an unmapped index must change nothing.
        cfg_index <= R_UNMAPPED;
        cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        poll_t         dir_polls[$];
        fixed_result_t fx;
        logic [31:0]   vals[8];
        int            phase_idle[4];
        int            phase_stall[4];

        phase_idle  = '{0, 78, 0, 17};
        phase_stall = '{0, 0, 78, 17};
        clear_model();

        // Directed rows: bus fault at start-up, retry, then a tour of the modes.
        dir_polls.push_back(make_poll(2'd0, 1'b0, 2'd0, DEV_BUS_FAIL, 16'hFFFF, 1'b1,
                                      CS_TOPOFF, 1'b1, '0, '0));
        for (int i = 0; i < 10; i++)
            dir_polls.push_back(make_poll(2'd1, 1'b1, 2'd3, 2'd3, 16'd0, 1'b0,
                                          CS_OFF, 1'b1, '0, '0));
        dir_polls.push_back(make_poll(2'd0, 1'b0, 2'd0, DEV_OK, 16'd3000, 1'b1,
                                      CS_CC, 1'b0, '0, '0));
        dir_polls.push_back(make_poll(2'd0, 1'b1, 2'd0, DEV_OK, 16'd3000, 1'b1,
                                      CS_CC, 1'b0, '0, '0));
        dir_polls.push_back(make_poll(2'd1, 1'b0, HEV_PACKET, DEV_OK, 16'd3000, 1'b1,
                                      CS_CC, 1'b0, '0, '0));
        dir_polls.push_back(make_poll(2'd3, 1'b0, HEV_SHUTDOWN, DEV_OK, 16'd3000, 1'b1,
                                      CS_TAPER, 1'b0, '0, '0));
        dir_polls.push_back(make_poll(2'd2, 1'b0, 2'd0, DEV_OK, 16'd3000, 1'b1,
                                      CS_CC, 1'b0, '1, '1));
        dir_polls.push_back(make_poll(2'd3, 1'b0, 2'd0, DEV_OK, 16'hFFFF, 1'b0,
                                      CS_OFF, 1'b1, '0, '0));
        dir_polls.push_back(make_poll(2'd2, 1'b1, 2'd0, DEV_OK, 16'd2000, 1'b0,
                                      CS_OFF, 1'b1, '0, '0));
        dir_polls.push_back(make_poll(2'd3, 1'b1, 2'd0, DEV_OK, 16'd2000, 1'b0,
                                      CS_OFF, 1'b1, '0, '0));

        // Values that can be read off at a glance: the start-up bus fault.
        fx.seq = 0;
        fx.res = '{low_battery: 1'b0, fault_reason: F_BUS, setup_wake_line: 1'b0,
                   charger_enabled: 1'b0, host_power_on: 1'b0, mode_state: M_FAULT};
        fixed_results.push_back(fx);
        fx.seq = 1;
        fx.res.low_battery = 1'b1;
        fixed_results.push_back(fx);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_polls[i])
            send_poll(dir_polls[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                1:
                begin
                    vals = '{32'd2900 + $urandom_range(300), 32'd3300 + $urandom_range(200),
                             32'd3600 + $urandom_range(200), 32'($urandom_range(1, 6)),
                             32'd1 << $urandom_range(31), $urandom & $urandom,
                             32'd1 << $urandom_range(7), 32'($urandom)};
                    write_regs(vals);
                end
                2:
                begin
                    vals = '{'1, 32'd5000, '1, '1, '1, '1, '1, '1};
                    write_regs(vals);
                end
                3:
                begin
                    vals = '{'0, '0, '0, '0, '0, '0, '0, '0};
                    write_regs(vals);
                end
                default:
                begin
                end
            endcase
            sender_idle_pct = phase_idle[ph];
            receiver_stall_pct = phase_stall[ph];
            pressure_phase = ph;
            for (int n = 0; n < PHASE_POLLS; n++)
                send_poll(random_poll(ph == 3 && n >= PHASE_POLLS - 60));
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bpmc_pkg.sv
hdl/bpmc_cfg.sv
hdl/bpmc_core.sv
hdl/battery_power_mode_controller.sv
dv/tb_top.sv
